// File: sv/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg: scanning line tracker shared definitions
// Field widths, register codes, reset values, the stage one record and the
// drive saturation function.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int POSITION_BITS = 12;
	localparam int SAMPLE_BITS   = 12;
	localparam int DRIVE_BITS    = 24;
	localparam int GAIN_BITS     = 16;
	localparam int FWD_BITS      = DRIVE_BITS - 1;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_WIDE_A     = (FWD_BITS > GAIN_BITS) ? FWD_BITS : GAIN_BITS;
	localparam int CFG_WIDE_B     = (POSITION_BITS > SAMPLE_BITS) ? POSITION_BITS : SAMPLE_BITS;
	localparam int CFG_DATA_BITS  = (CFG_WIDE_A > CFG_WIDE_B) ? CFG_WIDE_A : CFG_WIDE_B;

	// signed error times unsigned gain, then the forward term on top
	localparam int ERR_BITS   = POSITION_BITS + 1;
	localparam int STEER_BITS = GAIN_BITS + POSITION_BITS + 2;
	localparam int SUM_BITS   = ((STEER_BITS > DRIVE_BITS) ? STEER_BITS : DRIVE_BITS) + 1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DARK_LEVEL     = 3'd0,
		REG_SWEEP_MIN      = 3'd1,
		REG_SWEEP_MAX      = 3'd2,
		REG_CENTER_TARGET  = 3'd3,
		REG_FORWARD_SPEED  = 3'd4,
		REG_STEER_GAIN     = 3'd5
	} cfg_reg_t;

	localparam logic [SAMPLE_BITS-1:0]   RST_DARK_LEVEL     = SAMPLE_BITS'(400);
	localparam logic [POSITION_BITS-1:0] RST_SWEEP_MIN      = POSITION_BITS'(200);
	localparam logic [POSITION_BITS-1:0] RST_SWEEP_MAX      = POSITION_BITS'(400);
	localparam logic [POSITION_BITS-1:0] RST_CENTER_TARGET  = POSITION_BITS'(300);
	localparam logic [FWD_BITS-1:0]      RST_FORWARD_SPEED  = FWD_BITS'(8389);
	localparam logic [GAIN_BITS-1:0]     RST_STEER_GAIN     = GAIN_BITS'(17);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0]   dark_level;
		logic [POSITION_BITS-1:0] sweep_min;
		logic [POSITION_BITS-1:0] sweep_max;
		logic [POSITION_BITS-1:0] center_target;
		logic [FWD_BITS-1:0]      forward_speed;
		logic [GAIN_BITS-1:0]     steer_gain;
	} cfg_t;

	typedef struct packed {
		logic [POSITION_BITS-1:0] position;
		logic                     seen;
		logic                     updated;
		logic [POSITION_BITS-1:0] entry_edge;
		logic [POSITION_BITS-1:0] exit_edge;
	} stage1_t;

	function automatic logic signed [DRIVE_BITS-1:0] saturate_drive(
		input logic signed [SUM_BITS-1:0] v
	);
		logic signed [SUM_BITS-1:0] hi;
		logic signed [SUM_BITS-1:0] lo;
		hi = SUM_BITS'($signed({1'b0, {(DRIVE_BITS-1){1'b1}}}));
		lo = SUM_BITS'($signed({1'b1, {(DRIVE_BITS-1){1'b0}}}));
		if (v > hi) begin
			return hi[DRIVE_BITS-1:0];
		end else if (v < lo) begin
			return lo[DRIVE_BITS-1:0];
		end
		return v[DRIVE_BITS-1:0];
	endfunction

endpackage

// File: sv/slt_in_if.sv
// ----------------------------------------------------------------------------
// slt_in_if: light sample channel
// Valid/ready channel carrying one light sensor conversion per transaction.
// ----------------------------------------------------------------------------
interface slt_in_if;
	logic                              valid;
	logic                              ready;
	logic [slt_pkg::SAMPLE_BITS-1:0]   light_sample;

	modport source (output valid, output light_sample, input ready);
	modport sink   (input valid, input light_sample, output ready);
endinterface

// File: sv/slt_out_if.sv
// ----------------------------------------------------------------------------
// slt_out_if: tracker result channel
// Valid/ready channel carrying servo position, line flag and motor drives.
// ----------------------------------------------------------------------------
interface slt_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [slt_pkg::POSITION_BITS-1:0]      servo_position;
	logic                                   line_seen;
	logic signed [slt_pkg::DRIVE_BITS-1:0]  left_drive;
	logic signed [slt_pkg::DRIVE_BITS-1:0]  right_drive;
	logic                                   drive_updated;

	modport source (
		output valid, output servo_position, output line_seen,
		output left_drive, output right_drive, output drive_updated,
		input ready
	);
	modport sink (
		input valid, input servo_position, input line_seen,
		input left_drive, input right_drive, input drive_updated,
		output ready
	);
endinterface

// File: sv/slt_sweep.sv
// ----------------------------------------------------------------------------
// slt_sweep: sweep stepper and edge detector
// Steps the servo position inside the window, detects line entry and exit
// and registers the outcome of each sample into the first pipeline stage.
// ----------------------------------------------------------------------------
module slt_sweep (
	input  logic              clk,
	input  logic              arst_n,
	input  slt_pkg::cfg_t     cfg,
	slt_in_if.sink            in_ch,
	output slt_pkg::stage1_t  stage_s1,
	output logic              valid_s1,
	input  logic              s1_ready
);

	localparam int P = slt_pkg::POSITION_BITS;

	logic [P-1:0] pos_q;
	logic [P-1:0] entry_q;
	logic [P-1:0] exit_q;
	logic         down_q;
	logic         was_seen_q;

	logic         accept;
	logic         dir_turn;
	logic         dir_step;
	logic [P+1:0] ext_pos;
	logic [P+1:0] stepped;
	logic [P+1:0] clamp_hi;
	logic [P+1:0] clamp_lo;
	logic [P-1:0] new_pos;
	logic         seen;
	logic         rise;
	logic         fall;
	logic [P-1:0] new_entry;
	logic [P-1:0] new_exit;
	logic         new_down;

	assign in_ch.ready = !valid_s1 || s1_ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		dir_turn = (pos_q <= cfg.sweep_min) ? 1'b0 : down_q;
		dir_step = (pos_q >= cfg.sweep_max) ? 1'b1 : dir_turn;
		ext_pos  = {2'b00, pos_q};
		// a step below zero wraps to all ones, which reads as -1 signed
		stepped  = dir_step ? (ext_pos - (P+2)'(1)) : (ext_pos + (P+2)'(1));
		clamp_hi = ($signed(stepped) > $signed({2'b00, cfg.sweep_max}))
			? {2'b00, cfg.sweep_max} : stepped;
		clamp_lo = ($signed(clamp_hi) < $signed({2'b00, cfg.sweep_min}))
			? {2'b00, cfg.sweep_min} : clamp_hi;
		new_pos  = clamp_lo[P-1:0];

		seen      = in_ch.light_sample < cfg.dark_level;
		rise      = seen && !was_seen_q;
		fall      = !seen && was_seen_q;
		new_entry = rise ? new_pos : entry_q;
		new_exit  = fall ? new_pos : exit_q;
		// losing the line turns the sweep around
		new_down  = fall ? !dir_step : dir_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= slt_pkg::RST_SWEEP_MIN;
			entry_q    <= slt_pkg::RST_SWEEP_MIN;
			exit_q     <= slt_pkg::RST_SWEEP_MAX;
			down_q     <= 1'b0;
			was_seen_q <= 1'b0;
			valid_s1   <= 1'b0;
		end else begin
			if (accept) begin
				pos_q      <= new_pos;
				entry_q    <= new_entry;
				exit_q     <= new_exit;
				down_q     <= new_down;
				was_seen_q <= seen;
				valid_s1   <= 1'b1;
			end else if (s1_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.position   <= new_pos;
			stage_s1.seen       <= seen;
			stage_s1.updated    <= rise || fall;
			stage_s1.entry_edge <= new_entry;
			stage_s1.exit_edge  <= new_exit;
		end
	end

`ifndef SYNTHESIS
	a_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (cfg.sweep_min <= cfg.sweep_max) |->
		(stage_s1.position >= cfg.sweep_min) && (stage_s1.position <= cfg.sweep_max))
		else $error("sweep position left the window");

	a_edge_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && stage_s1.updated |->
		(stage_s1.entry_edge == stage_s1.position) || (stage_s1.exit_edge == stage_s1.position))
		else $error("drive update without an edge at the current position");

	a_seen_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1 && (stage_s1.seen == was_seen_q) && (stage_s1.position == pos_q))
		else $error("stage one disagrees with sweep state");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_ready |=> valid_s1 && $stable(stage_s1))
		else $error("stage one changed while stalled");
`endif

endmodule

// File: sv/slt_drive.sv
// ----------------------------------------------------------------------------
// slt_drive: motor drive pipeline
// Edge centre and error, steering product, then forward mix with saturation
// into the output register, which also holds the drives between updates.
// ----------------------------------------------------------------------------
module slt_drive (
	input  logic              clk,
	input  logic              arst_n,
	input  slt_pkg::cfg_t     cfg,
	input  slt_pkg::stage1_t  stage_s1,
	input  logic              valid_s1,
	output logic              s1_ready,
	slt_out_if.source         out_ch
);

	localparam int P  = slt_pkg::POSITION_BITS;
	localparam int EW = slt_pkg::ERR_BITS;
	localparam int SW = slt_pkg::STEER_BITS;
	localparam int UW = slt_pkg::SUM_BITS;
	localparam int DW = slt_pkg::DRIVE_BITS;
	localparam int FW = slt_pkg::FWD_BITS;

	logic                 valid_s2;
	logic                 valid_s3;
	logic                 valid_s4;
	logic                 en_s2;
	logic                 en_s3;
	logic                 en_s4;

	logic signed [EW-1:0] err_s2;
	logic [P-1:0]         pos_s2;
	logic                 seen_s2;
	logic                 upd_s2;

	logic signed [SW-1:0] steer_s3;
	logic [P-1:0]         pos_s3;
	logic                 seen_s3;
	logic                 upd_s3;

	logic [P-1:0]         pos_s4;
	logic                 seen_s4;
	logic                 upd_s4;
	logic signed [DW-1:0] left_q;
	logic signed [DW-1:0] right_q;

	logic [P:0]           edge_sum;
	logic signed [EW-1:0] err_next;
	logic signed [SW-1:0] steer_next;
	logic signed [UW-1:0] fwd_ext;
	logic signed [UW-1:0] steer_ext;
	logic signed [UW-1:0] left_sum;
	logic signed [UW-1:0] right_sum;

	assign en_s4    = !valid_s4 || out_ch.ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign s1_ready = en_s2;

	always_comb begin
		edge_sum   = {1'b0, stage_s1.entry_edge} + {1'b0, stage_s1.exit_edge};
		err_next   = $signed({1'b0, cfg.center_target}) - $signed({1'b0, edge_sum[P:1]});
		steer_next = SW'($signed({1'b0, cfg.steer_gain})) * SW'(err_s2);
		fwd_ext    = $signed({{(UW-FW){1'b0}}, cfg.forward_speed});
		steer_ext  = $signed({{(UW-SW){steer_s3[SW-1]}}, steer_s3});
		left_sum   = fwd_ext - steer_ext;
		right_sum  = -(fwd_ext + steer_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			left_q   <= '0;
			right_q  <= '0;
		end else begin
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
				// hold the drives unless an edge recomputed them
				if (valid_s3 && upd_s3) begin
					left_q  <= slt_pkg::saturate_drive(left_sum);
					right_q <= slt_pkg::saturate_drive(right_sum);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			err_s2  <= err_next;
			pos_s2  <= stage_s1.position;
			seen_s2 <= stage_s1.seen;
			upd_s2  <= stage_s1.updated;
		end
		if (en_s3 && valid_s2) begin
			steer_s3 <= steer_next;
			pos_s3   <= pos_s2;
			seen_s3  <= seen_s2;
			upd_s3   <= upd_s2;
		end
		if (en_s4 && valid_s3) begin
			pos_s4  <= pos_s3;
			seen_s4 <= seen_s3;
			upd_s4  <= upd_s3;
		end
	end

	assign out_ch.valid          = valid_s4;
	assign out_ch.servo_position = pos_s4;
	assign out_ch.line_seen      = seen_s4;
	assign out_ch.left_drive     = left_q;
	assign out_ch.right_drive    = right_q;
	assign out_ch.drive_updated  = upd_s4;

endmodule

// File: sv/scanning_line_tracker_unit.sv
// ----------------------------------------------------------------------------
// scanning_line_tracker_unit: servo sweep line tracker
// Sweeps a light sensor across the line, records entry and exit edges and
// steers the two motor drives from the centre of the edges.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      light_sample
//   out_ch    out  valid/ready      servo_position, line_seen, left_drive,
//                                   right_drive, drive_updated
//   cfg       in   cfg_we           cfg_index, cfg_data
//
// One sample per cycle sustained while the output accepts; each result passes
// through four register stages (sweep, error, multiply, output register)
// after the edge that accepts its sample.
// Sweep state updates as each sample is accepted, so samples follow back to back.
// A stalled output holds every stage; the input stalls once all four are full.
// Reset loads the register defaults and parks the sweep at the low limit.
// ----------------------------------------------------------------------------
module scanning_line_tracker_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [slt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [slt_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	slt_in_if.sink                               in_ch,
	slt_out_if.source                            out_ch
);

	slt_pkg::cfg_t    cfg_q;
	slt_pkg::stage1_t stage_s1;
	logic             valid_s1;
	logic             s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_level     <= slt_pkg::RST_DARK_LEVEL;
			cfg_q.sweep_min      <= slt_pkg::RST_SWEEP_MIN;
			cfg_q.sweep_max      <= slt_pkg::RST_SWEEP_MAX;
			cfg_q.center_target  <= slt_pkg::RST_CENTER_TARGET;
			cfg_q.forward_speed  <= slt_pkg::RST_FORWARD_SPEED;
			cfg_q.steer_gain     <= slt_pkg::RST_STEER_GAIN;
		end else if (cfg_we) begin
			case (slt_pkg::cfg_reg_t'(cfg_index))
				slt_pkg::REG_DARK_LEVEL: begin
					cfg_q.dark_level <= cfg_data[slt_pkg::SAMPLE_BITS-1:0];
				end
				slt_pkg::REG_SWEEP_MIN: begin
					cfg_q.sweep_min <= cfg_data[slt_pkg::POSITION_BITS-1:0];
				end
				slt_pkg::REG_SWEEP_MAX: begin
					cfg_q.sweep_max <= cfg_data[slt_pkg::POSITION_BITS-1:0];
				end
				slt_pkg::REG_CENTER_TARGET: begin
					cfg_q.center_target <= cfg_data[slt_pkg::POSITION_BITS-1:0];
				end
				slt_pkg::REG_FORWARD_SPEED: begin
					cfg_q.forward_speed <= cfg_data[slt_pkg::FWD_BITS-1:0];
				end
				slt_pkg::REG_STEER_GAIN: begin
					cfg_q.steer_gain <= cfg_data[slt_pkg::GAIN_BITS-1:0];
				end
				default: begin
					// drop writes to unknown registers
				end
			endcase
		end
	end

	slt_sweep u_sweep (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_ch    (in_ch),
		.stage_s1 (stage_s1),
		.valid_s1 (valid_s1),
		.s1_ready (s1_ready)
	);

	slt_drive u_drive (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.stage_s1 (stage_s1),
		.valid_s1 (valid_s1),
		.s1_ready (s1_ready),
		.out_ch   (out_ch)
	);

endmodule

// File: tb/slt_tracker_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slt_tracker_checker: result predictor and comparator for the line tracker
// Follows register writes and accepted samples, predicts each tracker result
// with its own copy of the sweep and drive state, and compares every accepted
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module slt_tracker_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [slt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [slt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	slt_in_if                                   in_ch,
	slt_out_if                                  out_ch,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  results_checked,
	output int                                  drive_updates
);
	import slt_pkg::*;

	typedef struct packed {
		logic [POSITION_BITS-1:0]      servo_position;
		logic                          line_seen;
		logic signed [DRIVE_BITS-1:0]  left_drive;
		logic signed [DRIVE_BITS-1:0]  right_drive;
		logic                          drive_updated;
	} tracker_result_t;

	// register copy
	logic [SAMPLE_BITS-1:0]   threshold;
	logic [POSITION_BITS-1:0] win_lo;
	logic [POSITION_BITS-1:0] win_hi;
	logic [POSITION_BITS-1:0] setpoint;
	logic [FWD_BITS-1:0]      fwd;
	logic [GAIN_BITS-1:0]     gain;

	// tracker state copy
	logic [POSITION_BITS-1:0]     sweep_pos;
	logic                         heading_down;
	logic                         line_present;
	logic [POSITION_BITS-1:0]     entry_pos;
	logic [POSITION_BITS-1:0]     exit_pos;
	logic signed [DRIVE_BITS-1:0] left_hold;
	logic signed [DRIVE_BITS-1:0] right_hold;

	tracker_result_t queued_results[$];
	tracker_result_t want;

	function automatic logic signed [DRIVE_BITS-1:0] clip_drive(input longint v);
		longint top_val;
		longint bottom_val;
		top_val = (longint'(1) <<< (DRIVE_BITS-1)) - 1;
		bottom_val = -top_val - 1;
		if (v > top_val) begin
			v = top_val;
		end else if (v < bottom_val) begin
			v = bottom_val;
		end
		return v[DRIVE_BITS-1:0];
	endfunction

	function automatic void steer_drives();
		longint centre;
		longint err;
		longint steer;
		centre = (longint'(entry_pos) + longint'(exit_pos)) / 2;
		err = longint'(setpoint) - centre;
		steer = longint'(gain) * err;
		left_hold = clip_drive(longint'(fwd) - steer);
		right_hold = clip_drive(-(longint'(fwd) + steer));
	endfunction

	function automatic tracker_result_t advance_tracker(input logic [SAMPLE_BITS-1:0] sample);
		tracker_result_t r;
		int next_pos;
		logic seen;
		r.drive_updated = 1'b0;
		if (sweep_pos <= win_lo) begin
			heading_down = 1'b0;
		end
		if (sweep_pos >= win_hi) begin
			heading_down = 1'b1;
		end
		next_pos = int'(sweep_pos) + (heading_down ? -1 : 1);
		// upper clamp first, lower clamp wins on a reversed window
		if (next_pos > int'(win_hi)) begin
			next_pos = int'(win_hi);
		end
		if (next_pos < int'(win_lo)) begin
			next_pos = int'(win_lo);
		end
		sweep_pos = next_pos[POSITION_BITS-1:0];

		seen = sample < threshold;
		if (seen && !line_present) begin
			entry_pos = sweep_pos;
			steer_drives();
			r.drive_updated = 1'b1;
		end else if (!seen && line_present) begin
			exit_pos = sweep_pos;
			heading_down = !heading_down;
			steer_drives();
			r.drive_updated = 1'b1;
		end
		line_present = seen;

		r.servo_position = sweep_pos;
		r.line_seen = seen;
		r.left_drive = left_hold;
		r.right_drive = right_hold;
		return r;
	endfunction

	task automatic check_field(input string field, input longint exp_val, input longint got_val);
		if (exp_val != got_val) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, field, exp_val, got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold = RST_DARK_LEVEL;
			win_lo = RST_SWEEP_MIN;
			win_hi = RST_SWEEP_MAX;
			setpoint = RST_CENTER_TARGET;
			fwd = RST_FORWARD_SPEED;
			gain = RST_STEER_GAIN;
			sweep_pos = RST_SWEEP_MIN;
			heading_down = 1'b0;
			line_present = 1'b0;
			entry_pos = RST_SWEEP_MIN;
			exit_pos = RST_SWEEP_MAX;
			left_hold = '0;
			right_hold = '0;
			queued_results.delete();
			fail_count = 0;
			pending = 0;
			results_checked = 0;
			drive_updates = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DARK_LEVEL:     threshold = cfg_data[SAMPLE_BITS-1:0];
					REG_SWEEP_MIN:      win_lo = cfg_data[POSITION_BITS-1:0];
					REG_SWEEP_MAX:      win_hi = cfg_data[POSITION_BITS-1:0];
					REG_CENTER_TARGET:  setpoint = cfg_data[POSITION_BITS-1:0];
					REG_FORWARD_SPEED:  fwd = cfg_data[FWD_BITS-1:0];
					REG_STEER_GAIN:     gain = cfg_data[GAIN_BITS-1:0];
					default: ;
				endcase
			end

			if (in_ch.valid && in_ch.ready) begin
				queued_results.push_back(advance_tracker(in_ch.light_sample));
			end

			if (out_ch.valid && out_ch.ready) begin
				if (queued_results.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual position %0d",
						$time, out_ch.servo_position);
					fail_count++;
				end else begin
					want = queued_results.pop_front();
					check_field("servo_position", want.servo_position, out_ch.servo_position);
					check_field("line_seen", want.line_seen, out_ch.line_seen);
					check_field("left_drive", $signed(want.left_drive),
						$signed(out_ch.left_drive));
					check_field("right_drive", $signed(want.right_drive),
						$signed(out_ch.right_drive));
					check_field("drive_updated", want.drive_updated, out_ch.drive_updated);
					results_checked++;
					if (want.drive_updated) begin
						drive_updates++;
					end
				end
			end
			pending = queued_results.size();
		end
	end

endmodule

// File: tb/tb_scanning_line_tracker_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scanning_line_tracker_unit: testbench top for the line tracker
// Drives light samples in random bursts across a series of register settings,
// among them saturating drives and reversed and collapsed sweep windows,
// while the result side stalls on its own pattern; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_scanning_line_tracker_unit;
	import slt_pkg::*;

	typedef enum int {RX_STREAM, RX_COIN, RX_PATTERN, RX_HOLD} rx_mode_t;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;
	localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
	localparam int POSITION_MAX    = (1 << POSITION_BITS) - 1;
	localparam int FWD_MAX         = (1 << FWD_BITS) - 1;
	localparam int GAIN_MAX        = (1 << GAIN_BITS) - 1;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int SETTLE_CYCLES   = 8;
	localparam int SQUEEZE_CYCLES  = 64;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	slt_in_if  in_ch ();
	slt_out_if out_ch ();

	int          fail_count;
	int          pending;
	int          results_checked;
	int          drive_updates;
	bit          offering;
	bit          squeeze_armed;
	bit          squeeze_done;
	int          burst_left;
	int          settings_used;
	int          samples_sent;
	int unsigned cur_threshold;

	scanning_line_tracker_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	slt_tracker_checker result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.drive_updates   (drive_updates)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Timeout: %0d results still expected", pending);
		$display("Test completed with failures");
		$finish;
	end

	// bits above the register width carry junk and must be ignored
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned value,
		input int width);
		int unsigned junk;
		int unsigned mask;
		junk = $urandom;
		mask = (32'd1 << width) - 1;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_BITS'((junk & ~mask) | (value & mask));
		@(negedge clk);
	endtask

	task automatic apply_settings(input int unsigned thr, input int unsigned lo,
		input int unsigned hi, input int unsigned sp, input int unsigned fwd,
		input int unsigned gain);
		write_reg(REG_DARK_LEVEL, thr, SAMPLE_BITS);
		write_reg(REG_SWEEP_MIN, lo, POSITION_BITS);
		write_reg(REG_SWEEP_MAX, hi, POSITION_BITS);
		write_reg(REG_SPARE_6, 0, 0);
		write_reg(REG_CENTER_TARGET, sp, POSITION_BITS);
		write_reg(REG_FORWARD_SPEED, fwd, FWD_BITS);
		write_reg(REG_STEER_GAIN, gain, GAIN_BITS);
		write_reg(REG_SPARE_7, 0, 0);
		cfg_we <= 1'b0;
		cur_threshold = thr;
		settings_used++;
	endtask

	task automatic push_sample(input logic [SAMPLE_BITS-1:0] s);
		in_ch.valid <= 1'b1;
		in_ch.light_sample <= s;
		offering = 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		samples_sent++;
		@(negedge clk);
		// end the burst with a gap, or hold valid for the next transaction
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			offering = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(0, 24);
		end else begin
			burst_left--;
		end
	endtask

	task automatic settle();
		if (offering) begin
			in_ch.valid <= 1'b0;
			offering = 1'b0;
		end
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : receiver
		rx_mode_t mode;
		int seg_len;
		logic [7:0] pattern;
		out_ch.ready = 1'b0;
		forever begin
			seg_len = $urandom_range(16, 96);
			pattern = $urandom;
			case ($urandom_range(0, 7))
				0, 1, 2: mode = RX_STREAM;
				3, 4:    mode = RX_COIN;
				5, 6:    mode = RX_PATTERN;
				default: mode = RX_HOLD;
			endcase
			// one long hold-off while samples keep coming, to back up the pipeline
			if (squeeze_armed && !squeeze_done) begin
				mode = RX_HOLD;
				seg_len = SQUEEZE_CYCLES;
				squeeze_done = 1'b1;
			end
			for (int c = 0; c < seg_len; c++) begin
				@(negedge clk);
				case (mode)
					RX_STREAM:  out_ch.ready <= 1'b1;
					RX_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
					RX_PATTERN: out_ch.ready <= pattern[c % 8];
					default:    out_ch.ready <= 1'b0;
				endcase
			end
		end
	end

	initial begin : stimulus
		int unsigned lo;
		int unsigned hi;
		int unsigned pick;
		bit in_line;
		int run_left;
		logic [SAMPLE_BITS-1:0] s;

		in_ch.valid = 1'b0;
		in_ch.light_sample = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		offering = 1'b0;
		squeeze_armed = 1'b0;
		squeeze_done = 1'b0;
		settings_used = 1;
		samples_sent = 0;
		cur_threshold = RST_DARK_LEVEL;
		burst_left = $urandom_range(0, 24);
		in_line = 1'b0;
		run_left = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: threshold boundary, entry and exit edges
		push_sample(SAMPLE_BITS'(SAMPLE_MAX));
		push_sample('0);
		push_sample(SAMPLE_BITS'(399));
		push_sample(SAMPLE_BITS'(400));
		push_sample('0);
		push_sample(SAMPLE_BITS'(SAMPLE_MAX));
		settle();

		// window at the top, setpoint zero: both drives saturate high
		apply_settings(2048, 4000, POSITION_MAX, 0, FWD_MAX, GAIN_MAX);
		push_sample('0);
		push_sample(SAMPLE_BITS'(SAMPLE_MAX));
		push_sample('0);
		settle();

		// setpoint at the top, no forward speed: both drives saturate low
		apply_settings(SAMPLE_MAX, 0, 100, POSITION_MAX, 0, GAIN_MAX);
		push_sample(SAMPLE_BITS'(SAMPLE_MAX - 1));
		push_sample(SAMPLE_BITS'(SAMPLE_MAX));
		push_sample(SAMPLE_BITS'(SAMPLE_MAX - 1));
		settle();

		// reversed window, zero gain
		apply_settings(1, 3000, 100, 2000, 1234, 0);
		push_sample('0);
		push_sample(SAMPLE_BITS'(SAMPLE_MAX));
		push_sample('0);
		settle();

		// collapsed window at the bottom
		apply_settings(2000, 0, 0, 0, 100, 1);
		push_sample('0);
		push_sample(SAMPLE_BITS'(SAMPLE_MAX));
		push_sample('0);
		settle();

		// collapsed window at the top
		apply_settings(2000, POSITION_MAX, POSITION_MAX, POSITION_MAX, FWD_MAX, GAIN_MAX);
		push_sample(SAMPLE_BITS'(SAMPLE_MAX));
		push_sample('0);
		settle();

		squeeze_armed = 1'b1;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			lo = $urandom_range(0, POSITION_MAX);
			pick = $urandom_range(0, 9);
			if (ph == 0 || pick > 1) begin
				hi = lo + $urandom_range(1, 300);
				if (hi > POSITION_MAX) begin
					hi = POSITION_MAX;
				end
			end else if (pick == 1) begin
				hi = lo;
			end else begin
				hi = $urandom_range(0, lo);
			end
			apply_settings($urandom_range(1, SAMPLE_MAX), lo, hi,
				$urandom_range(0, POSITION_MAX), $urandom_range(0, FWD_MAX),
				$urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, GAIN_MAX));

			// alternate runs on and off the line, with some noise mixed in
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (run_left == 0) begin
					in_line = !in_line;
					run_left = in_line ? $urandom_range(1, 12) : $urandom_range(1, 30);
				end
				run_left--;
				if ($urandom_range(0, 9) == 0) begin
					s = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
				end else if (in_line) begin
					s = SAMPLE_BITS'($urandom_range(0, cur_threshold - 1));
				end else begin
					s = SAMPLE_BITS'($urandom_range(cur_threshold, SAMPLE_MAX));
				end
				push_sample(s);
			end
			settle();
		end

		$display("Sent %0d samples over %0d register settings, including saturating drives",
			samples_sent, settings_used);
		$display("and reversed and collapsed windows; %0d results checked, %0d drive updates.",
			results_checked, drive_updates);
		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/slt_pkg.sv
sv/slt_in_if.sv
sv/slt_out_if.sv
sv/slt_sweep.sv
sv/slt_drive.sv
sv/scanning_line_tracker_unit.sv
tb/slt_tracker_checker.sv
tb/tb_scanning_line_tracker_unit.sv
